>>> src/msrl_pkg.sv
`default_nettype none
package msrl_pkg;

   localparam int unsigned VAL_W = 24;
   localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
   localparam logic [6:0] LONG_RUN_PITCHES = 7'd100;

   typedef enum logic [2:0] {
      ACT_WIDTH_THR  = 3'd0,
      ACT_LENGTH_THR = 3'd1,
      ACT_SPACE      = 3'd2,
      ACT_CORNER_W   = 3'd3,
      ACT_CORNER_S   = 3'd4,
      ACT_SPACING_Q  = 3'd5,
      ACT_CORNER_Q   = 3'd6,
      ACT_NONE       = 3'd7
   } action_type;

   localparam logic [1:0] AGGR_LENGTH = 2'd1;
   localparam logic [1:0] AGGR_WIDTH  = 2'd2;

   localparam logic [2:0] CSR_WIRE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_PITCH       = 3'd1;
   localparam logic [2:0] CSR_EOL_SPACE   = 3'd2;
   localparam logic [2:0] CSR_EOL_WIDTH   = 3'd3;
   localparam logic [2:0] CSR_LW_SPACE    = 3'd4;
   localparam logic [2:0] CSR_CORNER_EOL  = 3'd5;

   typedef struct packed {
      logic [2:0]        action;
      logic [2:0]        row_index;
      logic [2:0]        column_index;
      logic [VAL_W-1:0]  entry_value;
      logic signed [31:0] box_x_low;
      logic signed [31:0] box_x_high;
      logic signed [31:0] box_y_low;
      logic signed [31:0] box_y_high;
      logic              direction;
      logic [1:0]        aggr_mode;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] space_value;
      logic             result_kind;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      action_type        action;
      logic [2:0]        row_index;
      logic [2:0]        column_index;
      logic [VAL_W-1:0]  entry_value;
      logic [VAL_W-1:0]  range_w;
      logic [VAL_W-1:0]  min_w;
      logic              long_run;
      logic              wide_mode;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WWALK,
      ST_LWALK,
      ST_CWALK,
      ST_READ,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

>>> src/metal_spacing_rule_lookup_top.sv
`default_nettype none
// Spacing rule lookup for one metal layer. Requests either load rule tables
// (width/length thresholds, width-by-length space table, corner rows; no
// response) or query a box and return one response with the spacing and a
// kind bit. A front pipeline measures the box and classifies it; a back
// sequencer walks thresholds one per cycle: a spacing query walks width and,
// for a long run, length thresholds; a corner query walks corner rows.
// Config registers must be written through csr_ only while no request is in
// flight; the block itself does not enforce this.
module metal_spacing_rule_lookup_top #(
   parameter int unsigned WIDTH_ROWS  = 8,
   parameter int unsigned LENGTH_COLS = 8,
   parameter int unsigned CORNER_ROWS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire msrl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output msrl_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [23:0]       csr_wdata
);
   logic [23:0] wire_width_ff, pitch_ff, eol_space_ff, eol_width_ff;
   logic [23:0] lw_space_ff, corner_eol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wire_width_ff <= '0;
         pitch_ff      <= 24'd1;
         eol_space_ff  <= '0;
         eol_width_ff  <= '0;
         lw_space_ff   <= '0;
         corner_eol_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            msrl_pkg::CSR_WIRE_WIDTH: wire_width_ff <= csr_wdata;
            msrl_pkg::CSR_PITCH:      pitch_ff      <= csr_wdata;
            msrl_pkg::CSR_EOL_SPACE:  eol_space_ff  <= csr_wdata;
            msrl_pkg::CSR_EOL_WIDTH:  eol_width_ff  <= csr_wdata;
            msrl_pkg::CSR_LW_SPACE:   lw_space_ff   <= csr_wdata;
            msrl_pkg::CSR_CORNER_EOL: corner_eol_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front-to-back hand-off
   logic               item_valid, item_ready;
   msrl_pkg::item_type item_data;
   logic [25:0]        run_length;

   msrl_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .wire_width(wire_width_ff), .track_pitch(pitch_ff),
      .item_valid, .item_ready, .item_data, .run_length
   );

   msrl_back #(
      .WIDTH_ROWS(WIDTH_ROWS), .LENGTH_COLS(LENGTH_COLS), .CORNER_ROWS(CORNER_ROWS)
   ) u_back (
      .clock, .reset, .item_valid, .item_ready, .item_data, .run_length,
      .max_eol_space(eol_space_ff), .max_eol_width(eol_width_ff),
      .larger_width_space(lw_space_ff), .corner_eol_width(corner_eol_ff),
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
`default_nettype wire

>>> src/msrl_front.sv
`default_nettype none
module msrl_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire msrl_pkg::req_type req_data,
   input  wire logic [23:0]       wire_width,
   input  wire logic [23:0]       track_pitch,
   output logic                   item_valid,
   input  wire logic              item_ready,
   output msrl_pkg::item_type     item_data,
   output logic [25:0]            run_length
);
   // stage 1: extents and products; stage 2: compare/classify
   logic                  s1_valid_ff;
   msrl_pkg::req_type     s1_req_ff;
   logic [23:0]           s1_wx_ff, s1_wy_ff;
   logic [30:0]           s1_lim_ff;
   logic [25:0]           s1_run_ff;
   logic                  s2_valid_ff, s2_valid_in;
   msrl_pkg::item_type    s2_item_ff, s2_item_in;
   logic [25:0]           s2_run_ff;
   logic                  s1_adv, s2_adv;

   function automatic logic [23:0] ext(input logic signed [31:0] lo,
                                       input logic signed [31:0] hi);
      logic signed [32:0] d;
      d = 33'(hi) - 33'(lo);
      if (d < 0) return 24'd0;
      if (d > 33'sd16777215) return 24'hFFFFFF;
      return d[23:0];
   endfunction

   assign s2_adv = !s2_valid_ff || item_ready;
   assign s1_adv = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= req_valid;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_adv && req_valid) begin
         s1_req_ff <= req_data;
         s1_wx_ff  <= ext(req_data.box_x_low, req_data.box_x_high);
         s1_wy_ff  <= ext(req_data.box_y_low, req_data.box_y_high);
         s1_lim_ff <= 31'(track_pitch) * 31'(msrl_pkg::LONG_RUN_PITCHES);
         s1_run_ff <= {1'b0, track_pitch, 1'b0} + 26'(wire_width);
      end
      if (s2_adv && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
         s2_run_ff  <= s1_run_ff;
      end
   end

   always_comb begin
      logic [23:0] rng;
      rng = s1_req_ff.direction ? s1_wx_ff : s1_wy_ff;
      s2_item_in.action       = msrl_pkg::action_type'(s1_req_ff.action);
      s2_item_in.row_index    = s1_req_ff.row_index;
      s2_item_in.column_index = s1_req_ff.column_index;
      s2_item_in.entry_value  = s1_req_ff.entry_value;
      s2_item_in.range_w      = rng;
      s2_item_in.min_w        = (s1_wx_ff < s1_wy_ff) ? s1_wx_ff : s1_wy_ff;
      s2_item_in.long_run     = (s1_req_ff.aggr_mode == msrl_pkg::AGGR_LENGTH) &&
                                (31'(rng) > s1_lim_ff);
      s2_item_in.wide_mode    = (s1_req_ff.aggr_mode == msrl_pkg::AGGR_WIDTH);
   end

   assign item_valid = s2_valid_ff;
   assign item_data  = s2_item_ff;
   assign run_length = s2_run_ff;
endmodule
`default_nettype wire

>>> src/msrl_back.sv
`default_nettype none
module msrl_back #(
   parameter int unsigned WIDTH_ROWS  = 8,
   parameter int unsigned LENGTH_COLS = 8,
   parameter int unsigned CORNER_ROWS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   output logic                    item_ready,
   input  wire msrl_pkg::item_type item_data,
   input  wire logic [25:0]        run_length,
   input  wire logic [23:0]        max_eol_space,
   input  wire logic [23:0]        max_eol_width,
   input  wire logic [23:0]        larger_width_space,
   input  wire logic [23:0]        corner_eol_width,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output msrl_pkg::rsp_type       rsp_data
);
   localparam int unsigned WB = (WIDTH_ROWS > 1) ? $clog2(WIDTH_ROWS) : 1;
   localparam int unsigned LB = (LENGTH_COLS > 1) ? $clog2(LENGTH_COLS) : 1;
   localparam int unsigned CB = (CORNER_ROWS > 1) ? $clog2(CORNER_ROWS) : 1;
   localparam int unsigned TB = WB + LB;

   logic [23:0] wthr_ff [WIDTH_ROWS];
   logic [23:0] lthr_ff [LENGTH_COLS];
   logic [23:0] cthr_ff [CORNER_ROWS];
   logic [23:0] csp_ff  [CORNER_ROWS];
   logic [23:0] table_mem [WIDTH_ROWS*LENGTH_COLS];
   logic [WIDTH_ROWS*LENGTH_COLS-1:0] tvalid_ff;

   msrl_pkg::state_type state_ff, state_in;
   msrl_pkg::item_type  it_ff;
   logic [25:0]         run_ff;
   logic [WB-1:0]       wi_ff, wi_in;
   logic [LB-1:0]       li_ff, li_in;
   logic [CB-1:0]       ci_ff, ci_in;
   logic [23:0]         rd_ff;
   logic                rdv_ff;
   logic                kind_ff;
   logic [23:0]         cres_ff;
   logic                rsp_valid_ff;
   msrl_pkg::rsp_type   rsp_ff;
   logic                take, eol_hit;
   logic [TB-1:0]       taddr;

   assign eol_hit = (it_ff.range_w < max_eol_width) && (max_eol_space != 24'd0);
   assign taddr = TB'(wi_ff * LENGTH_COLS + li_ff);

   function automatic msrl_pkg::rsp_type rsp_in();
      msrl_pkg::rsp_type r;
      logic [23:0] s;
      if (kind_ff) s = cres_ff;
      else begin
         s = eol_hit ? max_eol_space : (rdv_ff ? rd_ff : 24'd0);
         if (it_ff.wide_mode && larger_width_space > s) s = larger_width_space;
      end
      r.space_value = s;
      r.result_kind = kind_ff;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msrl_pkg::ST_IDLE: if (item_valid) begin
            unique case (item_data.action)
               msrl_pkg::ACT_SPACING_Q: state_in = msrl_pkg::ST_WWALK;
               msrl_pkg::ACT_CORNER_Q:  state_in = msrl_pkg::ST_CWALK;
               default:                 state_in = msrl_pkg::ST_IDLE;
            endcase
         end
         msrl_pkg::ST_WWALK:
            if (eol_hit) state_in = msrl_pkg::ST_READ;
            else if (wi_ff == '0 || wthr_ff[wi_ff] < it_ff.min_w)
               state_in = it_ff.long_run ? msrl_pkg::ST_LWALK : msrl_pkg::ST_READ;
         msrl_pkg::ST_LWALK:
            if (li_ff == '0 || 26'(lthr_ff[li_ff]) < run_ff) state_in = msrl_pkg::ST_READ;
         msrl_pkg::ST_CWALK:
            if (it_ff.min_w < corner_eol_width || ci_ff == '0 ||
                cthr_ff[ci_ff] < it_ff.min_w) state_in = msrl_pkg::ST_READ;
         msrl_pkg::ST_READ: state_in = msrl_pkg::ST_OUT;
         msrl_pkg::ST_OUT: if (!rsp_valid_ff || rsp_ready) state_in = msrl_pkg::ST_IDLE;
         default: state_in = msrl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      item_ready = (state_ff == msrl_pkg::ST_IDLE);
      take = item_ready && item_valid;
      wi_in = wi_ff;
      li_in = li_ff;
      ci_in = ci_ff;
      if (take) begin
         wi_in = WB'(WIDTH_ROWS - 1);
         li_in = '0;
         ci_in = CB'(CORNER_ROWS - 1);
      end else begin
         if (state_ff == msrl_pkg::ST_WWALK && state_in == msrl_pkg::ST_LWALK)
            li_in = LB'(LENGTH_COLS - 1);
         if (state_ff == msrl_pkg::ST_WWALK && state_in == msrl_pkg::ST_WWALK)
            wi_in = wi_ff - 1'b1;
         if (state_ff == msrl_pkg::ST_LWALK && state_in == msrl_pkg::ST_LWALK)
            li_in = li_ff - 1'b1;
         if (state_ff == msrl_pkg::ST_CWALK && state_in == msrl_pkg::ST_CWALK)
            ci_in = ci_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msrl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tvalid_ff <= '0;
         for (int i = 0; i < WIDTH_ROWS; i++) wthr_ff[i] <= msrl_pkg::ALL_ONES;
         for (int i = 0; i < LENGTH_COLS; i++) lthr_ff[i] <= msrl_pkg::ALL_ONES;
         for (int i = 0; i < CORNER_ROWS; i++) begin
            cthr_ff[i] <= msrl_pkg::ALL_ONES;
            csp_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == msrl_pkg::ST_OUT && state_in == msrl_pkg::ST_IDLE) ||
                         (rsp_valid_ff && !rsp_ready);
         if (take) begin
            unique case (item_data.action)
               msrl_pkg::ACT_WIDTH_THR:
                  if (32'(item_data.row_index) < WIDTH_ROWS)
                     wthr_ff[WB'(item_data.row_index)] <= item_data.entry_value;
               msrl_pkg::ACT_LENGTH_THR:
                  if (32'(item_data.column_index) < LENGTH_COLS)
                     lthr_ff[LB'(item_data.column_index)] <= item_data.entry_value;
               msrl_pkg::ACT_SPACE:
                  if (32'(item_data.row_index) < WIDTH_ROWS &&
                      32'(item_data.column_index) < LENGTH_COLS)
                     tvalid_ff[TB'(item_data.row_index * LENGTH_COLS +
                                    item_data.column_index)] <= 1'b1;
               msrl_pkg::ACT_CORNER_W:
                  if (32'(item_data.row_index) < CORNER_ROWS)
                     cthr_ff[CB'(item_data.row_index)] <= item_data.entry_value;
               msrl_pkg::ACT_CORNER_S:
                  if (32'(item_data.row_index) < CORNER_ROWS)
                     csp_ff[CB'(item_data.row_index)] <= item_data.entry_value;
               default: ;
            endcase
         end
      end
      wi_ff <= wi_in;
      li_ff <= li_in;
      ci_ff <= ci_in;
      if (take) begin
         it_ff  <= item_data;
         run_ff <= run_length;
         kind_ff <= (item_data.action == msrl_pkg::ACT_CORNER_Q);
         if (item_data.action == msrl_pkg::ACT_SPACE &&
             32'(item_data.row_index) < WIDTH_ROWS &&
             32'(item_data.column_index) < LENGTH_COLS)
            table_mem[TB'(item_data.row_index * LENGTH_COLS + item_data.column_index)]
               <= item_data.entry_value;
      end
      if (state_ff == msrl_pkg::ST_READ) begin
         rd_ff  <= table_mem[taddr];
         rdv_ff <= tvalid_ff[taddr];
      end
      if (state_ff == msrl_pkg::ST_CWALK && state_in == msrl_pkg::ST_READ)
         cres_ff <= (it_ff.min_w < corner_eol_width) ? 24'd0 : csp_ff[ci_ff];
      if (state_ff == msrl_pkg::ST_OUT && state_in == msrl_pkg::ST_IDLE)
         rsp_ff <= rsp_in();
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire
